// ----- src/wall_function_yplus_viscosity_macros.svh -----
// assertion macros for the wall function yplus block
// used by wall_function_yplus_viscosity.sv, no other dependencies
`ifndef WALL_FUNCTION_YPLUS_VISCOSITY_MACROS_SVH
`define WALL_FUNCTION_YPLUS_VISCOSITY_MACROS_SVH

// same-cycle implication, checked outside reset
`define WFYV_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wfyv assertion failed");

// next-cycle implication, checked outside reset
`define WFYV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wfyv assertion failed");

`endif

// ----- src/wfyv_pkg.sv -----
// package for the wall function yplus block: fixed-point constants,
// register indexes and the sequencer state type; no dependencies
`default_nettype none

package wfyv_pkg;

    localparam int MAX_UPDATES_DEF = 10;

    localparam logic [47:0] QONE   = 48'h0001_0000_0000;
    localparam logic [47:0] QMAX   = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [40:0] MAG_POS_MAX = 41'h0FF_FFFF_FFFF;
    localparam logic [40:0] MAG_NEG_MAX = 41'h100_0000_0000;

    localparam logic [15:0] KAPPA_RST = 16'd26870;
    localparam logic [23:0] E_RST     = 24'd642253;
    localparam logic [23:0] LAM_RST   = 24'd755630;

    typedef enum logic [1:0] {
        CFG_KAPPA = 2'd0,
        CFG_E     = 2'd1,
        CFG_LAM   = 2'd2
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_KR1,
        S_KR2,
        S_KR3,
        S_KR4,
        S_IT_START,
        S_IT_LN,
        S_IT_DIV,
        S_IT_CHK,
        S_TL_CMP,
        S_TL_LN,
        S_TL_T,
        S_TL_Q,
        S_TL_MU,
        S_TL_FIN,
        S_DONE,
        S_MUL,
        S_DIV_INIT,
        S_DIV_RUN,
        S_LN_INIT,
        S_LN_NORM,
        S_LN_SQ,
        S_LN_FRC,
        S_LN_INT
    } t_state;

endpackage

`default_nettype wire

// ----- src/wall_function_yplus_viscosity.sv -----
// wall function yplus / turbulent wall viscosity, one shared datapath
// depends on wfyv_pkg and wall_function_yplus_viscosity_macros.svh
//
// usage: present a wall face on the i_* fields and pulse start while busy
// is low; the request is taken at that edge and busy stays high until the
// result is shown. the result (o_yplus, o_turbulent_viscosity,
// o_update_count) is valid for exactly one cycle with o_done high; there is
// no back pressure, the receiver must take it then. the next request may be
// given the cycle after o_done.
// config: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data; ready is
// always high, writes are meant for idle time; unknown indexes are dropped.
// sequence: kappa*Re first, then each update (a 64x64 multiply built from
// a shared 32x32 multiplier, a log with 32 squaring steps, a radix-2
// divider), then the viscosity; a saturating division skips its 48-step
// loop. one face at a time.
// reset: state goes idle and the three constants return to their defaults.
`default_nettype none

`include "wall_function_yplus_viscosity_macros.svh"

module wall_function_yplus_viscosity #(
    parameter int MAX_UPDATES = wfyv_pkg::MAX_UPDATES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [31:0]        i_velocity_magnitude,
    input  wire logic [31:0]        i_wall_distance,
    input  wire logic [31:0]        i_density,
    input  wire logic [39:0]        i_laminar_viscosity,
    output logic                    o_done,
    output logic [31:0]             o_yplus,
    output logic signed [40:0]      o_turbulent_viscosity,
    output logic [3:0]              o_update_count,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire wfyv_pkg::t_cfg_idx i_cfg_index,
    input  wire logic [23:0]        i_cfg_data
);
    import wfyv_pkg::*;

    localparam int CW = $clog2(MAX_UPDATES + 1);

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    logic [15:0]  r_kap;
    logic [23:0]  r_e, r_lam;
    logic [31:0]  r_u, n_u, r_rho, n_rho;
    logic [39:0]  r_mu, n_mu;
    logic [63:0]  r_ma, n_ma, r_mb, n_mb;
    logic [127:0] r_acc, n_acc;
    logic [5:0]   r_cnt, n_cnt;
    logic [127:0] r_dnum, n_dnum;
    logic [63:0]  r_dvs, n_dvs, r_rem, n_rem;
    logic [47:0]  r_quo, n_quo;
    logic [47:0]  r_lnx, n_lnx;
    logic [3:0]   r_k, n_k;
    logic [31:0]  r_m, n_m, r_frac, n_frac, r_lnf, n_lnf;
    logic [47:0]  r_ln, n_ln;
    logic [63:0]  r_t, n_t;
    logic [47:0]  r_kr, n_kr, r_yp, n_yp;
    logic [CW-1:0] r_upd, n_upd;
    logic         r_neg, n_neg;
    logic [31:0]  r_yplus, n_yplus;
    logic [40:0]  r_mut, n_mut;
    logic [3:0]   r_cnt_o, n_cnt_o;

    // shared multiplier core
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // common decisions
    logic [47:0] shr16_sat;
    logic [48:0] yp_sum;
    logic [47:0] num_sat;
    logic [47:0] diff;
    logic [54:0] diff100;
    logic        it_cont;
    logic        tl_big;
    logic        div_sat;
    logic [64:0] div_trial;
    logic        div_ge;
    logic [3:0]  ln_sh;
    logic        ln_topz;
    logic [47:0] ln_xn;
    logic [32:0] sq_t;
    logic [6:0]  mul_sh;
    logic [63:0] tl_mag;
    logic [40:0] tl_m41;

    assign shr16_sat = (|r_acc[127:64]) ? QMAX : r_acc[63:16];
    assign yp_sum    = {1'b0, r_kr} + {1'b0, r_yp};
    assign num_sat   = yp_sum[48] ? QMAX : yp_sum[47:0];
    assign diff      = (r_quo >= r_yp) ? (r_quo - r_yp) : (r_yp - r_quo);
    assign diff100   = 55'(diff) * 55'd100;
    // keep going while the change is large and the update limit is not hit
    assign it_cont   = (diff100 > 55'({r_lam, 16'b0}))
                    && (32'(r_upd) + 32'd1 < 32'(MAX_UPDATES));
    assign tl_big    = r_yp[47:16] > 32'(r_lam);
    assign div_sat   = (|r_dnum[127:112]) || (r_dnum[111:48] >= r_dvs);
    assign div_trial = {r_rem, r_dnum[47]};
    assign div_ge    = div_trial >= {1'b0, r_dvs};
    assign ln_sh     = 4'd8 >> r_cnt[1:0];
    assign ln_topz   = (r_lnx >> (6'd48 - {2'b0, ln_sh})) == 48'd0;
    assign ln_xn     = ln_topz ? (r_lnx << ln_sh) : r_lnx;
    assign sq_t      = mul_p[63:31];
    assign mul_sh    = ({6'b0, r_cnt[1]} + {6'b0, r_cnt[0]}) << 5;
    assign tl_mag    = r_acc[95:32];

    always_comb begin
        if (r_neg) begin
            tl_m41 = ((|r_acc[127:96]) || (tl_mag > 64'(MAG_NEG_MAX)))
                   ? MAG_NEG_MAX : tl_mag[40:0];
        end else begin
            tl_m41 = ((|r_acc[127:96]) || (tl_mag > 64'(MAG_POS_MAX)))
                   ? MAG_POS_MAX : tl_mag[40:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (start) n_state = S_MUL;
            S_KR1:      n_state = S_MUL;
            S_KR2:      n_state = S_MUL;
            S_KR3:      n_state = S_DIV_INIT;
            S_KR4:      n_state = S_IT_START;
            S_IT_START: n_state = S_MUL;
            S_IT_LN:    n_state = S_LN_INIT;
            S_IT_DIV:   n_state = S_DIV_INIT;
            S_IT_CHK:   n_state = it_cont ? S_IT_START : S_TL_CMP;
            S_TL_CMP:   n_state = tl_big ? S_MUL : S_DONE;
            S_TL_LN:    n_state = S_LN_INIT;
            S_TL_T:     n_state = S_MUL;
            S_TL_Q:     n_state = S_DIV_INIT;
            S_TL_MU:    n_state = S_MUL;
            S_TL_FIN:   n_state = S_DONE;
            S_DONE:     n_state = S_IDLE;
            S_MUL:      if (r_cnt[1:0] == 2'd3) n_state = r_ret;
            S_DIV_INIT: n_state = div_sat ? r_ret : S_DIV_RUN;
            S_DIV_RUN:  if (r_cnt == 6'd47) n_state = r_ret;
            S_LN_INIT:  n_state = S_LN_NORM;
            S_LN_NORM:  if (r_cnt[1:0] == 2'd3) n_state = S_LN_SQ;
            S_LN_SQ:    if (r_cnt == 6'd31) n_state = S_LN_FRC;
            S_LN_FRC:   n_state = S_LN_INT;
            S_LN_INT:   n_state = r_ret;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs and multiplier operand select
    always_comb begin
        busy        = r_state != S_IDLE;
        o_done      = r_state == S_DONE;
        o_cfg_ready = 1'b1;
        mul_a       = 32'd0;
        mul_b       = 32'd0;
        unique case (r_state)
            S_MUL: begin
                mul_a = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
                mul_b = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
            end
            S_LN_SQ: begin
                mul_a = r_m;
                mul_b = r_m;
            end
            S_LN_FRC: begin
                mul_a = r_frac;
                mul_b = LN2_Q32;
            end
            S_LN_INT: begin
                mul_a = 32'(r_k);
                mul_b = LN2_Q32;
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_ret = r_ret;   n_u = r_u;       n_rho = r_rho;   n_mu = r_mu;
        n_ma = r_ma;     n_mb = r_mb;     n_acc = r_acc;   n_cnt = r_cnt;
        n_dnum = r_dnum; n_dvs = r_dvs;   n_rem = r_rem;   n_quo = r_quo;
        n_lnx = r_lnx;   n_k = r_k;       n_m = r_m;       n_frac = r_frac;
        n_lnf = r_lnf;   n_ln = r_ln;     n_t = r_t;       n_kr = r_kr;
        n_yp = r_yp;     n_upd = r_upd;   n_neg = r_neg;
        n_yplus = r_yplus; n_mut = r_mut; n_cnt_o = r_cnt_o;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_u   = i_velocity_magnitude;
                    n_rho = i_density;
                    n_mu  = i_laminar_viscosity;
                    n_ma  = 64'(r_kap);
                    n_mb  = 64'(i_wall_distance);
                    n_acc = '0;
                    n_cnt = '0;
                    n_ret = S_KR1;
                end
            end
            S_KR1: begin
                n_t   = r_acc[63:0];
                n_ma  = 64'(r_u);
                n_mb  = 64'(r_rho);
                n_acc = '0;
                n_cnt = '0;
                n_ret = S_KR2;
            end
            S_KR2: begin
                n_ma  = r_t;
                n_mb  = r_acc[63:0];
                n_acc = '0;
                n_cnt = '0;
                n_ret = S_KR3;
            end
            S_KR3: begin
                n_dnum = r_acc;
                n_dvs  = {8'b0, r_mu, 16'b0};
                n_ret  = S_KR4;
            end
            S_KR4: begin
                n_kr  = r_quo;
                n_yp  = {8'b0, r_lam, 16'b0};
                n_upd = '0;
            end
            S_IT_START: begin
                n_ma  = 64'(r_e);
                n_mb  = 64'(r_yp);
                n_acc = '0;
                n_cnt = '0;
                n_ret = S_IT_LN;
            end
            S_IT_LN: begin
                n_lnx = shr16_sat;
                n_ret = S_IT_DIV;
            end
            S_IT_DIV: begin
                n_dnum = {48'b0, num_sat, 32'b0};
                n_dvs  = 64'(r_ln) + 64'(QONE);
                n_ret  = S_IT_CHK;
            end
            S_IT_CHK: begin
                n_yp  = r_quo;
                n_upd = r_upd + CW'(1);
            end
            S_TL_CMP: begin
                n_yplus = r_yp[47:16];
                n_cnt_o = (32'(r_upd) > 32'd15) ? 4'd15 : 4'(r_upd);
                n_mut   = '0;
                if (tl_big) begin
                    n_ma  = 64'(r_e);
                    n_mb  = {16'b0, r_yp[47:16], 16'b0};
                    n_acc = '0;
                    n_cnt = '0;
                    n_ret = S_TL_LN;
                end
            end
            S_TL_LN: begin
                n_lnx = shr16_sat;
                n_ret = S_TL_T;
            end
            S_TL_T: begin
                n_t   = 64'(r_ln);
                n_ma  = {16'b0, r_yplus, 16'b0};
                n_mb  = 64'(r_kap);
                n_acc = '0;
                n_cnt = '0;
                n_ret = S_TL_Q;
            end
            S_TL_Q: begin
                n_dnum = {48'b0, shr16_sat, 32'b0};
                n_dvs  = r_t;
                n_ret  = S_TL_MU;
            end
            S_TL_MU: begin
                if (r_quo >= QONE) begin
                    n_mb  = 64'(r_quo - QONE);
                    n_neg = 1'b0;
                end else begin
                    n_mb  = 64'(QONE - r_quo);
                    n_neg = 1'b1;
                end
                n_ma  = 64'(r_mu);
                n_acc = '0;
                n_cnt = '0;
                n_ret = S_TL_FIN;
            end
            S_TL_FIN: begin
                n_mut = r_neg ? (~tl_m41 + 41'd1) : tl_m41;
            end
            S_MUL: begin
                n_acc = r_acc + ({64'b0, mul_p} << mul_sh);
                n_cnt = r_cnt + 6'd1;
            end
            S_DIV_INIT: begin
                n_cnt = '0;
                if (div_sat) begin
                    n_quo = QMAX;
                end else begin
                    n_rem = r_dnum[111:48];
                end
            end
            S_DIV_RUN: begin
                // restoring step, remainder always below the divisor
                n_rem  = div_ge ? 64'(div_trial - {1'b0, r_dvs}) : div_trial[63:0];
                n_quo  = {r_quo[46:0], div_ge};
                n_dnum = r_dnum << 1;
                n_cnt  = r_cnt + 6'd1;
            end
            S_LN_INIT: begin
                n_lnx = (r_lnx < QONE) ? QONE : r_lnx;
                n_k   = 4'd15;
                n_cnt = '0;
            end
            S_LN_NORM: begin
                n_lnx = ln_xn;
                if (ln_topz) n_k = r_k - ln_sh;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt[1:0] == 2'd3) begin
                    n_m    = ln_xn[47:16];
                    n_frac = '0;
                    n_cnt  = '0;
                end
            end
            S_LN_SQ: begin
                // square the mantissa, one fraction bit of log2 per step
                if (sq_t[32]) begin
                    n_m    = sq_t[32:1];
                    n_frac = r_frac | (32'h8000_0000 >> r_cnt[4:0]);
                end else begin
                    n_m = sq_t[31:0];
                end
                n_cnt = r_cnt + 6'd1;
            end
            S_LN_FRC: begin
                n_lnf = mul_p[63:32];
            end
            S_LN_INT: begin
                n_ln = 48'(mul_p) + 48'(r_lnf);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kap <= KAPPA_RST;
            r_e   <= E_RST;
            r_lam <= LAM_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KAPPA: r_kap <= i_cfg_data[15:0];
                CFG_E:     r_e   <= i_cfg_data;
                CFG_LAM:   r_lam <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;   r_u <= n_u;       r_rho <= n_rho;   r_mu <= n_mu;
        r_ma <= n_ma;     r_mb <= n_mb;     r_acc <= n_acc;   r_cnt <= n_cnt;
        r_dnum <= n_dnum; r_dvs <= n_dvs;   r_rem <= n_rem;   r_quo <= n_quo;
        r_lnx <= n_lnx;   r_k <= n_k;       r_m <= n_m;       r_frac <= n_frac;
        r_lnf <= n_lnf;   r_ln <= n_ln;     r_t <= n_t;       r_kr <= n_kr;
        r_yp <= n_yp;     r_upd <= n_upd;   r_neg <= n_neg;
        r_yplus <= n_yplus; r_mut <= n_mut; r_cnt_o <= n_cnt_o;
    end

    assign o_yplus               = r_yplus;
    assign o_turbulent_viscosity = r_mut;
    assign o_update_count        = r_cnt_o;

    `WFYV_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `WFYV_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `WFYV_ASSERT_SAME(a_count_nonzero, i_clk, i_rst_n, o_done, o_update_count != 4'd0)
    `WFYV_ASSERT_SAME(a_lam_zero_mut, i_clk, i_rst_n,
        o_done && (o_yplus <= 32'(r_lam)), o_turbulent_viscosity == 41'sd0)
    `WFYV_ASSERT_SAME(a_div_rem, i_clk, i_rst_n, r_state == S_DIV_RUN, r_rem < r_dvs)

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// testbench for wall_function_yplus_viscosity: directed, configuration and random faces
// predicts yplus, wall turbulent viscosity and update count in fixed point; uses wfyv_pkg
module tb;
    import wfyv_pkg::*;

    localparam t_cfg_idx CFG_NONE = t_cfg_idx'(2'd3);
    localparam int       WDOG_LIMIT = 6000;
    localparam int       SETTLE_CYCLES = 40;
    localparam int       UPDATE_LIMIT = 10;

    typedef struct packed {
        logic [31:0] yplus;
        logic [40:0] mut;
        logic [3:0]  count;
    } t_face_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [31:0]        i_velocity_magnitude;
    logic [31:0]        i_wall_distance;
    logic [31:0]        i_density;
    logic [39:0]        i_laminar_viscosity;
    logic               o_done;
    logic [31:0]        o_yplus;
    logic signed [40:0] o_turbulent_viscosity;
    logic [3:0]         o_update_count;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    t_cfg_idx           i_cfg_index;
    logic [23:0]        i_cfg_data;

    // predictor copy of the registers
    logic [15:0] kappa_q;
    logic [23:0] loge_q;
    logic [23:0] lam_q;

    t_face_result expected_faces[$];
    int faces_sent;
    int faces_checked;
    int turbulent_seen;
    int fail_count;
    int idle_cycles;

    wall_function_yplus_viscosity uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_velocity_magnitude  (i_velocity_magnitude),
        .i_wall_distance       (i_wall_distance),
        .i_density             (i_density),
        .i_laminar_viscosity   (i_laminar_viscosity),
        .o_done                (o_done),
        .o_yplus               (o_yplus),
        .o_turbulent_viscosity (o_turbulent_viscosity),
        .o_update_count        (o_update_count),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- fixed-point predictor ----------------

    function automatic logic [63:0] sat_shift(input logic [127:0] p, input int sh);
        logic [127:0] s;
        s = p >> sh;
        if (s > {80'd0, QMAX}) return {16'd0, QMAX};
        return s[63:0];
    endfunction

    function automatic logic [63:0] sat_quot(input logic [127:0] n, input logic [63:0] d);
        logic [127:0] q;
        if (n[127:112] != 16'd0) return {16'd0, QMAX};
        if (n[111:48] >= d) return {16'd0, QMAX};
        q = n / {64'd0, d};
        return q[63:0];
    endfunction

    function automatic logic [63:0] log_q32(input logic [63:0] x_in);
        logic [63:0] x, m, frac, ln2, ip, fp;
        int p;
        x = x_in;
        ln2 = {32'd0, LN2_Q32};
        if (x < {16'd0, QONE}) x = {16'd0, QONE};
        if (x > {16'd0, QMAX}) x = {16'd0, QMAX};
        p = 47;
        while (!x[p]) p--;
        m = x >> (p - 31);
        frac = 64'd0;
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            if (m >= {16'd0, QONE}) begin
                m = m >> 1;
                frac[31 - i] = 1'b1;
            end
        end
        ip = 64'(p - 32) * ln2;
        fp = (frac * ln2) >> 32;
        return ip + fp;
    endfunction

    function automatic t_face_result predict_face(input logic [31:0] u, input logic [31:0] y,
                                                  input logic [31:0] rho,
                                                  input logic [39:0] mu);
        t_face_result r;
        logic [63:0] kr, yp, last, den, num, diff, lamq, yq, lnv, t, q, qone, qmax, mag;
        logic [127:0] prod;
        int count;
        qone = {16'd0, QONE};
        qmax = {16'd0, QMAX};
        lamq = {24'd0, lam_q, 16'd0};
        prod = 128'(64'(kappa_q) * 64'(y)) * 128'(64'(u) * 64'(rho));
        kr = sat_quot(prod, {8'd0, mu, 16'd0});
        yp = lamq;
        count = 0;
        forever begin
            last = yp;
            den = qone + log_q32(sat_shift(128'(loge_q) * 128'(yp), 16));
            num = kr + yp;
            if (num > qmax) num = qmax;
            yp = sat_quot(128'({num, 32'd0}), den);
            count++;
            diff = (yp >= last) ? yp - last : last - yp;
            if (!(diff * 64'd100 > lamq)) break;
            if (count >= UPDATE_LIMIT) break;
        end
        r.yplus = yp[47:16];
        r.mut = 41'd0;
        if ({8'd0, r.yplus} > {16'd0, lam_q}) begin
            yq = {16'd0, r.yplus, 16'd0};
            lnv = log_q32(sat_shift(128'(loge_q) * 128'(yq), 16));
            t = sat_shift(128'(yq) * 128'(kappa_q), 16);
            q = sat_quot(128'({t, 32'd0}), lnv);
            if (q >= qone) begin
                prod = (128'(mu) * 128'(q - qone)) >> 32;
                mag = (prod > 128'(MAG_POS_MAX)) ? 64'(MAG_POS_MAX) : prod[63:0];
                r.mut = mag[40:0];
            end else begin
                prod = (128'(mu) * 128'(qone - q)) >> 32;
                mag = (prod > 128'(MAG_NEG_MAX)) ? 64'(MAG_NEG_MAX) : prod[63:0];
                r.mut = 41'd0 - mag[40:0];
            end
        end
        r.count = (count > 15) ? 4'd15 : 4'(count);
        return r;
    endfunction

    // ---------------- result checker and watchdog ----------------

    always @(posedge i_clk) begin
        t_face_result want;
        if (i_rst_n && o_done) begin
            if (expected_faces.size() == 0) begin
                $error("result with no request pending: yplus %h", o_yplus);
                fail_count++;
            end else begin
                want = expected_faces.pop_front();
                faces_checked++;
                if (want.mut != 41'd0) turbulent_seen++;
                if (o_yplus !== want.yplus) begin
                    $error("yplus expected %h actual %h", want.yplus, o_yplus);
                    fail_count++;
                end
                if (o_turbulent_viscosity !== want.mut) begin
                    $error("turbulent_viscosity expected %h actual %h", want.mut,
                           o_turbulent_viscosity);
                    fail_count++;
                end
                if (o_update_count !== want.count) begin
                    $error("update_count expected %0d actual %0d", want.count,
                           o_update_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog expired, %0d results pending", expected_faces.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------- drivers ----------------

    task automatic send_face(input logic [31:0] u, input logic [31:0] y,
                             input logic [31:0] rho, input logic [39:0] mu);
        @(negedge i_clk);
        start <= 1'b1;
        i_velocity_magnitude <= u;
        i_wall_distance <= y;
        i_density <= rho;
        i_laminar_viscosity <= mu;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        expected_faces.push_back(predict_face(u, y, rho, mu));
        faces_sent++;
    endtask

    task automatic hold_off(input int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain();
        hold_off(1);
        while (expected_faces.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [23:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            CFG_KAPPA: kappa_q = data[15:0];
            CFG_E:     loge_q = data;
            CFG_LAM:   lam_q = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_constants(input logic [15:0] k, input logic [23:0] e,
                                 input logic [23:0] lam);
        drain();
        write_reg(CFG_KAPPA, {8'd0, k});
        write_reg(CFG_E, e);
        write_reg(CFG_LAM, lam);
    endtask

    // value with a random bit length, sometimes all ones
    function automatic logic [63:0] rand_bits(input int w);
        logic [63:0] v;
        int k;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0) k = w;
        else k = $urandom_range(0, w);
        if ($urandom_range(0, 15) == 0) return (64'd1 << w) - 1;
        return v & ((64'd1 << k) - 1);
    endfunction

    task automatic send_random_face();
        logic [31:0] u, y, rho;
        logic [39:0] mu;
        if ($urandom_range(0, 3) != 0) begin
            // plausible flow: moderate velocity, small distance, unit-ish density
            u   = $urandom_range(32'h0000_1000, 32'h0064_0000);
            y   = $urandom_range(0, 32'h0100_0000);
            rho = $urandom_range(32'h0010_0000, 32'h0400_0000);
            mu  = 40'($urandom_range(1, 32'h0800_0000));
        end else begin
            u   = 32'(rand_bits(32));
            y   = 32'(rand_bits(32));
            rho = 32'(rand_bits(32));
            mu  = 40'(rand_bits(40));
        end
        if (rho == 32'd0) rho = 32'd1;
        if (mu == 40'd0) mu = 40'd1;
        send_face(u, y, rho, mu);
    endtask

    task automatic random_faces(input int n);
        int left, burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst && left > 0; i++) begin
                send_random_face();
                left--;
            end
            if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 400));
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_faces();
        send_face(32'd0, 32'd0, 32'd1, 40'd1);
        send_face(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'd1);
        send_face(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
        send_face(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
        send_face(32'd655360, 32'd4294967, 32'h0100_0000, 40'd19791209);
        send_face(32'd655360, 32'd429497, 32'h0100_0000, 40'd19791209);
        send_face(32'd6553600, 32'd42949673, 32'h0100_0000, 40'd19791209);
        send_face(32'd65536, 32'd42949, 32'h0100_0000, 40'd19791209);
        send_face(32'd1, 32'd1, 32'd1, 40'hFF_FFFF_FFFF);
        send_face(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 40'h80_0000_0000);
        send_face(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 40'hAA_AAAA_AAAA);
        send_face(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 40'h55_5555_5555);
    endtask

    task automatic test_config_extremes();
        // smallest constants, then largest, then an index that maps to nothing
        set_constants(16'd1, 24'd65536, 24'd65536);
        test_directed_faces();
        set_constants(16'hFFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        test_directed_faces();
        drain();
        write_reg(CFG_NONE, 24'hFF_FFFF);
        test_directed_faces();
        set_constants(KAPPA_RST, E_RST, LAM_RST);
    endtask

    task automatic test_random_settings();
        random_faces(150);
        // wait for all pending results once mid-stream
        drain();
        random_faces(150);
        for (int ph = 0; ph < 4; ph++) begin
            set_constants(16'($urandom_range(1, 65535)), 24'($urandom_range(65536, 24'hFF_FFFF)),
                          24'($urandom_range(65536, 24'h1F_FFFF)));
            random_faces(170);
        end
        set_constants(KAPPA_RST, E_RST, LAM_RST);
        random_faces(120);
    endtask

    initial begin
        start = 1'b0;
        i_velocity_magnitude = 32'd0;
        i_wall_distance = 32'd0;
        i_density = 32'd0;
        i_laminar_viscosity = 40'd0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_KAPPA;
        i_cfg_data = 24'd0;
        kappa_q = KAPPA_RST;
        loge_q = E_RST;
        lam_q = LAM_RST;
        faces_sent = 0;
        faces_checked = 0;
        turbulent_seen = 0;
        fail_count = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_faces();
        test_config_extremes();
        test_random_settings();
        drain();

        $display("covered %0d faces, %0d checked, %0d with nonzero wall viscosity",
                 faces_sent, faces_checked, turbulent_seen);
        $display("constants swept over defaults, extremes and random settings");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+src
src/wfyv_pkg.sv
src/wall_function_yplus_viscosity.sv
sim/tb.sv
